// ===== rtl/bprd_pkg.sv =====
// ----------------------------------------------------------------------------
// bprd_pkg
// Shared types, widths and helpers for the bit-pair run-length plane decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bprd_pkg;

  // largest tile count per side; the pair counter and repeat count are sized for it
  localparam int MAX_TILES = 7;

  // field and state widths
  localparam int TILE_W  = 3;   // width_tiles / height_tiles registers
  localparam int PAIRS_W = 11;  // pair counter, repeat count
  localparam int VAL_W   = 12;  // prefix/suffix value, saturating
  localparam int LEN_W   = 5;   // prefix length, suffix bits left
  localparam int SHIFT_W = 5;   // 32 pairs per tile

  // configuration register indexes
  localparam logic CFG_WIDTH_TILES  = 1'b0;
  localparam logic CFG_HEIGHT_TILES = 1'b1;

  // packet decoder phase
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_PREFIX = 5'b00010,
    PH_SUFFIX = 5'b00100,
    PH_LIT_A  = 5'b01000,
    PH_LIT_B  = 5'b10000
  } phase_t;

  // one input beat as held in the input register
  typedef struct packed {
    logic action;
    logic bit_value;
  } bprd_beat_t;

  // shift one bit into a value, sticking at all ones once it overflows;
  // any value past the largest plane behaves the same in the count clip
  function automatic logic [VAL_W-1:0] sat_shift(input logic [VAL_W-1:0] v,
                                                 input logic b);
    logic [VAL_W:0] n;
    n = {v, b};
    return n[VAL_W] ? {VAL_W{1'b1}} : n[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bprd_if.sv =====
// ----------------------------------------------------------------------------
// bprd_in_if / bprd_out_if
// Valid/ready channels for compressed bits in and decoded pair runs out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bprd_in_if;
  logic valid;
  logic ready;
  logic action;
  logic bit_value;

  modport source (output valid, output action, output bit_value, input ready);
  modport sink   (input valid, input action, input bit_value, output ready);
endinterface

interface bprd_out_if;
  logic        valid;
  logic        ready;
  logic        pair_high;
  logic        pair_low;
  logic [10:0] repeat_count;
  logic        plane_done;

  modport source (output valid, output pair_high, output pair_low,
                  output repeat_count, output plane_done, input ready);
  modport sink   (input valid, input pair_high, input pair_low,
                  input repeat_count, input plane_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/bprd_cfg.sv =====
// ----------------------------------------------------------------------------
// bprd_cfg
// Tile count registers and the pair count of one plane.
// ----------------------------------------------------------------------------
`default_nettype none

module bprd_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [bprd_pkg::TILE_W-1:0]  cfg_wdata,
  output logic      [bprd_pkg::PAIRS_W-1:0] plane_pairs
);
  import bprd_pkg::*;

  localparam int TC_W = 4;  // holds MAX_TILES up to 15
  localparam logic [TC_W-1:0] MaxTiles = TC_W'(MAX_TILES);
  localparam logic [TILE_W-1:0] TileReset = TILE_W'(7);

  logic [TILE_W-1:0]   width_tiles_r;
  logic [TILE_W-1:0]   height_tiles_r;
  logic [TC_W-1:0]     w_eff;
  logic [TC_W-1:0]     h_eff;
  logic [2*TC_W-1:0]   tiles;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_tiles_r  <= TileReset;
      height_tiles_r <= TileReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH_TILES:  width_tiles_r  <= cfg_wdata;
        CFG_HEIGHT_TILES: height_tiles_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp each count to 1..MAX_TILES
  function automatic logic [TC_W-1:0] clamp_tiles(input logic [TILE_W-1:0] t);
    logic [TC_W-1:0] e;
    e = TC_W'(t);
    priority if (e == '0)      return TC_W'(1);
    else if (e > MaxTiles)     return MaxTiles;
    else                       return e;
  endfunction

  assign w_eff = clamp_tiles(width_tiles_r);
  assign h_eff = clamp_tiles(height_tiles_r);
  assign tiles = w_eff * h_eff;

  // 32 pairs per tile
  assign plane_pairs = PAIRS_W'({tiles, {SHIFT_W{1'b0}}});

endmodule

`default_nettype wire

// ===== rtl/bprd_in_stage.sv =====
// ----------------------------------------------------------------------------
// bprd_in_stage
// Input register: holds one compressed-bit beat until the decoder takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bprd_in_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  bprd_in_if.sink                   in_ch,
  output logic                      s1_valid,
  output bprd_pkg::bprd_beat_t      s1_beat,
  input  wire logic                 s1_take
);
  import bprd_pkg::*;

  logic       s1_valid_r;
  bprd_beat_t s1_beat_r;

  // free when empty or emptied this cycle
  assign in_ch.ready = !s1_valid_r || s1_take;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_beat_r.action    <= in_ch.action;
      s1_beat_r.bit_value <= in_ch.bit_value;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_beat  = s1_beat_r;

endmodule

`default_nettype wire

// ===== rtl/bprd_decode.sv =====
// ----------------------------------------------------------------------------
// bprd_decode
// Packet state machine (run prefix/suffix, literal pairs) and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bprd_decode (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          s1_valid,
  input  wire bprd_pkg::bprd_beat_t          s1_beat,
  output logic                               s1_take,
  input  wire logic [bprd_pkg::PAIRS_W-1:0]  plane_pairs,
  bprd_out_if.source                         out_ch
);
  import bprd_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [PAIRS_W-1:0]  pairs_left_r, pairs_left_nxt;
  logic [VAL_W-1:0]    prefix_val_r, prefix_val_nxt;
  logic [LEN_W-1:0]    prefix_len_r, prefix_len_nxt;
  logic [VAL_W-1:0]    suffix_val_r, suffix_val_nxt;
  logic [LEN_W-1:0]    suffix_left_r, suffix_left_nxt;
  logic                held_r, held_nxt;

  logic                out_valid_r;
  logic                out_hi_r, out_lo_r, out_done_r;
  logic [PAIRS_W-1:0]  out_cnt_r;

  logic                emit;
  logic                emit_hi, emit_lo;
  logic [PAIRS_W-1:0]  emit_cnt;
  logic [VAL_W-1:0]    pre_shift, suf_shift;
  logic [LEN_W-1:0]    len_inc;
  logic [VAL_W:0]      total;
  logic                slot_free;
  logic                bit_in;

  assign bit_in    = s1_beat.bit_value;
  assign pre_shift = sat_shift(prefix_val_r, bit_in);
  assign suf_shift = sat_shift(suffix_val_r, bit_in);
  assign len_inc   = (prefix_len_r == {LEN_W{1'b1}}) ? prefix_len_r
                                                      : prefix_len_r + LEN_W'(1);
  // run length before clipping
  assign total = {1'b0, prefix_val_r} + {1'b0, suf_shift} + (VAL_W+1)'(1);

  // next state for the beat in the input register
  always_comb begin
    phase_nxt       = phase_r;
    pairs_left_nxt  = pairs_left_r;
    prefix_val_nxt  = prefix_val_r;
    prefix_len_nxt  = prefix_len_r;
    suffix_val_nxt  = suffix_val_r;
    suffix_left_nxt = suffix_left_r;
    held_nxt        = held_r;
    emit            = 1'b0;
    emit_hi         = 1'b0;
    emit_lo         = 1'b0;
    emit_cnt        = '0;

    if (!s1_beat.action) begin
      // plane start: bit picks the first packet type
      pairs_left_nxt = plane_pairs;
      held_nxt       = 1'b0;
      if (!bit_in) begin
        phase_nxt       = PH_PREFIX;
        prefix_val_nxt  = '0;
        prefix_len_nxt  = '0;
        suffix_val_nxt  = '0;
        suffix_left_nxt = '0;
      end else begin
        phase_nxt = PH_LIT_A;
      end
    end else begin
      unique case (phase_r)
        PH_PREFIX: begin
          prefix_val_nxt = pre_shift;
          prefix_len_nxt = len_inc;
          if (!bit_in) begin
            suffix_left_nxt = len_inc;
            suffix_val_nxt  = '0;
            phase_nxt       = PH_SUFFIX;
          end
        end
        PH_SUFFIX: begin
          suffix_val_nxt = suf_shift;
          if (suffix_left_r != '0) suffix_left_nxt = suffix_left_r - LEN_W'(1);
          if (suffix_left_r <= LEN_W'(1)) begin
            // last suffix bit: emit the run, clipped to what is left
            emit      = 1'b1;
            emit_cnt  = (total < (VAL_W+1)'(pairs_left_r)) ? total[PAIRS_W-1:0]
                                                           : pairs_left_r;
            phase_nxt = PH_LIT_A;
          end
        end
        PH_LIT_A: begin
          held_nxt  = bit_in;
          phase_nxt = PH_LIT_B;
        end
        PH_LIT_B: begin
          if (!held_r && !bit_in) begin
            // pair 00 closes the literal packet
            phase_nxt       = PH_PREFIX;
            prefix_val_nxt  = '0;
            prefix_len_nxt  = '0;
            suffix_val_nxt  = '0;
            suffix_left_nxt = '0;
          end else begin
            emit      = 1'b1;
            emit_hi   = held_r;
            emit_lo   = bit_in;
            emit_cnt  = PAIRS_W'(1);
            phase_nxt = PH_LIT_A;
          end
        end
        PH_IDLE: phase_nxt = PH_IDLE;
        default: phase_nxt = PH_IDLE;
      endcase
    end

    // count down and close the plane on its last pair
    if (emit) begin
      pairs_left_nxt = pairs_left_r - emit_cnt;
      if (pairs_left_nxt == '0) phase_nxt = PH_IDLE;
    end
  end

  // take the beat unless its result has nowhere to go
  assign slot_free = !out_valid_r || out_ch.ready;
  assign s1_take   = s1_valid && (!emit || slot_free);

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      pairs_left_r  <= '0;
      prefix_val_r  <= '0;
      prefix_len_r  <= '0;
      suffix_val_r  <= '0;
      suffix_left_r <= '0;
      held_r        <= 1'b0;
    end else if (s1_take) begin
      phase_r       <= phase_nxt;
      pairs_left_r  <= pairs_left_nxt;
      prefix_val_r  <= prefix_val_nxt;
      prefix_len_r  <= prefix_len_nxt;
      suffix_val_r  <= suffix_val_nxt;
      suffix_left_r <= suffix_left_nxt;
      held_r        <= held_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_take && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_take && emit) begin
      out_hi_r   <= emit_hi;
      out_lo_r   <= emit_lo;
      out_cnt_r  <= emit_cnt;
      out_done_r <= (pairs_left_nxt == '0);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pair_high    = out_hi_r;
  assign out_ch.pair_low     = out_lo_r;
  assign out_ch.repeat_count = out_cnt_r;
  assign out_ch.plane_done   = out_done_r;

endmodule

`default_nettype wire

// ===== rtl/bit_pair_rle_plane_decoder_top.sv =====
// The bit that completes a result beat passes the input register, then the result
//   register, before the beat shows on out_ch.
// Throughput: one bit per cycle unless stalled; the packet state updates in one pass.
// A bit whose result finds the result register full waits in the input register.
// Reset (rst_n low, synchronous): decoder idle, no plane active, both tile counts 7.
// ----------------------------------------------------------------------------
// bit_pair_rle_plane_decoder_top
// Serial bit-pair run-length bitplane decoder: compressed bits in, pair runs out.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_pair_rle_plane_decoder_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  bprd_in_if.sink                          in_ch,
  bprd_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [bprd_pkg::TILE_W-1:0] cfg_wdata
);
  import bprd_pkg::*;

  logic               s1_valid;
  bprd_beat_t         s1_beat;
  logic               s1_take;
  logic [PAIRS_W-1:0] plane_pairs;

  // tile registers and plane size
  bprd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .plane_pairs (plane_pairs)
  );

  // input register
  bprd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .s1_valid (s1_valid),
    .s1_beat  (s1_beat),
    .s1_take  (s1_take)
  );

  // packet decoder and result register
  bprd_decode u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid),
    .s1_beat     (s1_beat),
    .s1_take     (s1_take),
    .plane_pairs (plane_pairs),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/bprd_checker.sv =====
// ----------------------------------------------------------------------------
// bprd_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bprd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_pair_high,
  input wire logic        out_pair_low,
  input wire logic [10:0] out_repeat_count,
  input wire logic        out_plane_done
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pair_high) &&
      $stable(out_pair_low) && $stable(out_repeat_count) && $stable(out_plane_done))
    else $error("result beat changed while stalled");

  // a literal pair is never repeated
  a_lit_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pair_high || out_pair_low) |-> out_repeat_count == 11'd1)
    else $error("literal pair with repeat count other than one");

  // run length stays within one plane
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_repeat_count != 11'd0 && out_repeat_count <= 11'd1568)
    else $error("repeat count out of range");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind bit_pair_rle_plane_decoder_top bprd_checker u_bprd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_pair_high    (out_ch.pair_high),
  .out_pair_low     (out_ch.pair_low),
  .out_repeat_count (out_ch.repeat_count),
  .out_plane_done   (out_ch.plane_done)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the bit-pair run-length plane decoder against a cycle-free decoder
// kept in the bench: directed packets first, then random planes of random
// size with noise, broken planes, tile register changes and stalls.
// ----------------------------------------------------------------------------

module testbench;
  import bprd_pkg::*;

  localparam int       VAL_MAX     = 'h1FFFF;
  localparam int       LEN_MAX     = 31;
  localparam int       WATCHDOG    = 2000;
  localparam int       PHASE_BEATS = 140;
  localparam int       PHASES      = 10;
  localparam logic     ACT_START   = 1'b0;
  localparam logic     ACT_BIT     = 1'b1;

  // one decoded run of a pixel pair
  typedef struct packed {
    logic        pair_high;
    logic        pair_low;
    logic [10:0] repeat_count;
    logic        plane_done;
  } pair_run_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [TILE_W-1:0] cfg_wdata;

  bprd_in_if  in_ch ();
  bprd_out_if out_ch ();

  bit_pair_rle_plane_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bprd_beat_t pending_bits[$];
  pair_run_t  expected_runs[$];
  bprd_beat_t tx_beat;
  int         errors = 0;
  int         tx_gap = 0;
  int         rx_stall = 0;
  int         idle_cycles = 0;
  bit         quiet = 1'b0;

  // decoder state mirrored in the bench
  logic [TILE_W-1:0] tiles_w = 3'd7;
  logic [TILE_W-1:0] tiles_h = 3'd7;
  phase_t            dec_phase = PH_IDLE;
  logic [10:0]       dec_left = '0;
  logic [16:0]       run_prefix = '0;
  logic [4:0]        run_len = '0;
  logic [16:0]       run_suffix = '0;
  logic [4:0]        suffix_todo = '0;
  logic              lit_first = 1'b0;

  function automatic int clamp_tiles(input logic [TILE_W-1:0] t);
    if (t == 0) return 1;
    if (int'(t) > MAX_TILES) return MAX_TILES;
    return int'(t);
  endfunction

  function automatic logic [16:0] shift_sat(input logic [16:0] v, input logic b);
    int n;
    n = (int'(v) << 1) | int'(b);
    return (n > VAL_MAX) ? 17'(VAL_MAX) : 17'(n);
  endfunction

  function automatic void start_run();
    dec_phase   = PH_PREFIX;
    run_prefix  = '0;
    run_len     = '0;
    run_suffix  = '0;
    suffix_todo = '0;
  endfunction

  function automatic void emit_run(input logic hi, input logic lo, input int cnt);
    pair_run_t r;
    dec_left       = dec_left - 11'(cnt);
    r.pair_high    = hi;
    r.pair_low     = lo;
    r.repeat_count = 11'(cnt);
    r.plane_done   = (dec_left == 0);
    expected_runs.push_back(r);
    dec_phase = (dec_left == 0) ? PH_IDLE : PH_LIT_A;
  endfunction

  // advance the mirrored decoder by one accepted beat
  function automatic void decode_beat(input bprd_beat_t b);
    int total;
    if (b.action == ACT_START) begin
      dec_left  = 11'(clamp_tiles(tiles_w) * clamp_tiles(tiles_h) * 32);
      lit_first = 1'b0;
      if (b.bit_value == 1'b0) start_run();
      else dec_phase = PH_LIT_A;
      return;
    end
    case (dec_phase)
      PH_PREFIX: begin
        run_prefix = shift_sat(run_prefix, b.bit_value);
        if (run_len < LEN_MAX) run_len = run_len + 1'b1;
        if (b.bit_value == 1'b0) begin
          suffix_todo = run_len;
          run_suffix  = '0;
          dec_phase   = PH_SUFFIX;
        end
      end
      PH_SUFFIX: begin
        run_suffix = shift_sat(run_suffix, b.bit_value);
        if (suffix_todo > 0) suffix_todo = suffix_todo - 1'b1;
        if (suffix_todo == 0) begin
          total = int'(run_prefix) + int'(run_suffix) + 1;
          emit_run(1'b0, 1'b0, (total < int'(dec_left)) ? total : int'(dec_left));
        end
      end
      PH_LIT_A: begin
        lit_first = b.bit_value;
        dec_phase = PH_LIT_B;
      end
      PH_LIT_B: begin
        if (!lit_first && !b.bit_value) start_run();
        else emit_run(lit_first, b.bit_value, 1);
      end
      default: dec_phase = PH_IDLE;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void push_bit(input logic act, input logic b);
    bprd_beat_t x;
    x.action    = act;
    x.bit_value = b;
    pending_bits.push_back(x);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) decode_beat(tx_beat);
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_ch.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          tx_gap = $urandom_range(0, 10);
          in_ch.valid <= 1'b0;
        end else if (pending_bits.size() != 0) begin
          tx_beat = pending_bits.pop_front();
          in_ch.action    <= tx_beat.action;
          in_ch.bit_value <= tx_beat.bit_value;
          in_ch.valid     <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready stalls
  always @(posedge clk) begin
    pair_run_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_runs.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_runs.pop_front();
          if (out_ch.pair_high !== want.pair_high)
            report_mismatch($sformatf("pair_high %b, want %b", out_ch.pair_high,
                                      want.pair_high));
          if (out_ch.pair_low !== want.pair_low)
            report_mismatch($sformatf("pair_low %b, want %b", out_ch.pair_low,
                                      want.pair_low));
          if (out_ch.repeat_count !== want.repeat_count)
            report_mismatch($sformatf("repeat_count %0d, want %0d",
                                      out_ch.repeat_count, want.repeat_count));
          if (out_ch.plane_done !== want.plane_done)
            report_mismatch($sformatf("plane_done %b, want %b", out_ch.plane_done,
                                      want.plane_done));
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_stall = $urandom_range(0, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat and no register write
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("[bit_pair_rle_plane_decoder_top] ERROR");
        $finish;
      end
    end
  end

  // wait until sender is empty and every expected run has come out
  task automatic drain();
    while (!(pending_bits.size() == 0 && !in_ch.valid && expected_runs.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tiles(input logic [TILE_W-1:0] w, input logic [TILE_W-1:0] h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH_TILES;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT_TILES;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    tiles_w = w;
    tiles_h = h;
    @(negedge clk);
  endtask

  // one plane of alternating packets, sometimes cut short
  task automatic queue_plane(input int beat_cap);
    int     left;
    int     k;
    int     slen;
    int     nlit;
    int     npk;
    int     p;
    logic   b;
    logic   kind;
    longint pv;
    longint sv;
    longint cnt;
    left = clamp_tiles(tiles_w) * clamp_tiles(tiles_h) * 32;
    kind = 1'($urandom_range(0, 1));
    push_bit(ACT_START, kind);
    npk = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 100000;
    while (left > 0 && npk > 0 && pending_bits.size() < beat_cap) begin
      npk--;
      if (kind == 1'b0) begin
        // run packet: k ones, a zero, then k+1 suffix bits, at most 31
        p = $urandom_range(0, 99);
        if (p < 3) k = $urandom_range(28, 34);
        else if (left > 300 && p < 25) k = $urandom_range(8, 12);
        else if (p < 10) k = $urandom_range(4, 10);
        else k = $urandom_range(0, 3);
        pv = 0;
        repeat (k) begin
          push_bit(ACT_BIT, 1'b1);
          pv = pv * 2 + 1;
        end
        push_bit(ACT_BIT, 1'b0);
        pv   = pv * 2;
        slen = (k + 1 > LEN_MAX) ? LEN_MAX : k + 1;
        sv   = 0;
        repeat (slen) begin
          b = 1'($urandom_range(0, 1));
          push_bit(ACT_BIT, b);
          sv = sv * 2 + b;
        end
        cnt  = pv + sv + 1;
        left = (cnt < left) ? left - int'(cnt) : 0;
      end else begin
        // literal packet: nonzero pairs closed by 00
        nlit = $urandom_range(0, 6);
        for (int i = 0; i < nlit && left > 0; i++) begin
          p = $urandom_range(1, 3);
          push_bit(ACT_BIT, p[1]);
          push_bit(ACT_BIT, p[0]);
          left--;
        end
        if (left > 0) begin
          push_bit(ACT_BIT, 1'b0);
          push_bit(ACT_BIT, 1'b0);
        end
      end
      if ($urandom_range(0, 19) == 0) push_bit(ACT_BIT, 1'($urandom_range(0, 1)));
      kind = ~kind;
    end
    // bits past the end of the plane are dropped
    repeat ($urandom_range(0, 2)) push_bit(ACT_BIT, 1'($urandom_range(0, 1)));
  endtask

  task automatic queue_phase(input int beats);
    int cap;
    cap = pending_bits.size() + beats;
    // carry on the plane left open by the previous phase
    if ($urandom_range(0, 1) == 0)
      repeat ($urandom_range(2, 12)) push_bit(ACT_BIT, 1'($urandom_range(0, 1)));
    while (pending_bits.size() < cap) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 8))
          push_bit(($urandom_range(0, 7) == 0) ? ACT_START : ACT_BIT,
                   1'($urandom_range(0, 1)));
      end else begin
        queue_plane(cap);
      end
    end
  endtask

  // stimulus sequence
  initial begin
    logic [TILE_W-1:0] w;
    logic [TILE_W-1:0] h;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_WIDTH_TILES;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_BIT;
    in_ch.bit_value = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: one tile, every packet kind
    write_tiles(3'd1, 3'd1);
    push_bit(ACT_BIT, 1'b1);                   // bits with no plane active
    push_bit(ACT_BIT, 1'b0);
    push_bit(ACT_START, 1'b1);                 // literal first
    push_bit(ACT_BIT, 1'b1); push_bit(ACT_BIT, 1'b1);
    push_bit(ACT_BIT, 1'b0); push_bit(ACT_BIT, 1'b1);
    push_bit(ACT_BIT, 1'b0); push_bit(ACT_BIT, 1'b0);   // end literal
    push_bit(ACT_BIT, 1'b1); push_bit(ACT_BIT, 1'b1); push_bit(ACT_BIT, 1'b0);
    push_bit(ACT_BIT, 1'b1); push_bit(ACT_BIT, 1'b0); push_bit(ACT_BIT, 1'b1);
    push_bit(ACT_START, 1'b0);                 // restart mid plane with a run
    push_bit(ACT_BIT, 1'b0); push_bit(ACT_BIT, 1'b1);
    push_bit(ACT_BIT, 1'b1); push_bit(ACT_BIT, 1'b1); // literal pair 11 after the run, then 11 again
    push_bit(ACT_BIT, 1'b1); push_bit(ACT_BIT, 1'b1); push_bit(ACT_BIT, 1'b0);
    repeat (5) push_bit(ACT_BIT, 1'b0);
    push_bit(ACT_BIT, 1'b1);                   // a prefix bit; the plane stays open
    drain();

    // random phases with changing plane sizes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin w = 3'd0; h = 3'd0; end
        1: begin w = 3'd7; h = 3'd7; end
        2: begin w = 3'd7; h = 3'd1; end
        3: begin w = 3'd1; h = 3'd7; end
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            w = 3'($urandom_range(0, 7));
            h = 3'($urandom_range(0, 7));
          end else begin
            w = 3'($urandom_range(0, 2));
            h = 3'($urandom_range(0, 2));
          end
        end
      endcase
      write_tiles(w, h);
      if (ph >= PHASES - 2) quiet = 1'b1;
      queue_phase(PHASE_BEATS);
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[bit_pair_rle_plane_decoder_top] OK");
    end else begin
      $display("[bit_pair_rle_plane_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
